[src/annexb_nal_deframer_core_macros.svh]
// ----------------------------------------------------------------------------
// annexb assertion macros
// shared concurrent assertion forms for the deframer checker
// ----------------------------------------------------------------------------
`ifndef ANNEXB_NAL_DEFRAMER_CORE_MACROS_SVH
`define ANNEXB_NAL_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication
`define ANNEXB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ANNEXB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/annexb_pkg.sv]
// ----------------------------------------------------------------------------
// annexb_pkg
// shared types and constants of the annex b nal deframer
// ----------------------------------------------------------------------------
package annexb_pkg;

	localparam int LENGTH_WIDTH = 24;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;
	localparam logic [7:0] BYTE_ESC  = 8'h03;

	localparam logic [1:0] HELD_MAX = 2'd3;
	localparam logic [1:0] RUN_MAX  = 2'd2;
	localparam logic [1:0] HDR_DONE = 2'd2;

	typedef enum logic [1:0] {
		OP_ZERO  = 2'd0,
		OP_DATA  = 2'd1,
		OP_START = 2'd2,
		OP_CLOSE = 2'd3
	} op_code_t;

	typedef struct packed {
		logic       valid;
		op_code_t   code;
		logic [7:0] data;
		logic       long_sc;
	} op_t;

	typedef struct packed {
		logic                    kind;
		logic [7:0]              byte_val;
		logic                    hdr_valid;
		logic                    forbidden;
		logic [5:0]              unit_type;
		logic [5:0]              layer_id;
		logic [2:0]              tid_plus1;
		logic                    long_prefix;
		logic                    err;
		logic [LENGTH_WIDTH-1:0] length;
	} item_t;

endpackage

[src/annexb_seq.sv]
// ----------------------------------------------------------------------------
// annexb_seq
// input register, held-zero tracking and per-byte operation sequencer
// ----------------------------------------------------------------------------
module annexb_seq
	import annexb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] stream_byte,
	input  logic       end_of_stream,
	input  logic       op_ready,
	output op_t        op
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic [1:0] held_q;
	logic [2:0] ph_q;

	logic       is_zero;
	logic       is_start;
	logic [1:0] nz;
	logic       has_main;
	logic [2:0] total;
	logic       last;
	logic       done;
	logic       take;
	op_code_t   cur_code;

	always_comb begin
		is_zero  = (byte_s1 == BYTE_ZERO);
		is_start = (byte_s1 == BYTE_ONE) && held_q[1];
		nz       = (is_zero || is_start) ? 2'd0 : held_q;
		has_main = !is_zero;
		total    = 3'(nz) + 3'(has_main) + 3'(eos_s1);
		last     = (total == 3'd0) || (ph_q == total - 3'd1);
		if (ph_q < {1'b0, nz}) begin
			cur_code = OP_ZERO;
		end else if (ph_q == {1'b0, nz} && has_main) begin
			cur_code = is_start ? OP_START : OP_DATA;
		end else begin
			cur_code = OP_CLOSE;
		end
		op.valid   = valid_s1 && (total != 3'd0);
		op.code    = cur_code;
		op.data    = byte_s1;
		op.long_sc = (held_q == HELD_MAX);
		done       = valid_s1 && ((total == 3'd0) || (op_ready && last));
		byte_stall = valid_s1 && !done;
		take       = byte_valid && !byte_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			held_q   <= 2'd0;
			ph_q     <= 3'd0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				ph_q <= 3'd0;
				if (eos_s1) begin
					held_q <= 2'd0;
				end else if (is_zero) begin
					if (held_q != HELD_MAX) begin
						held_q <= held_q + 2'd1;
					end
				end else begin
					held_q <= 2'd0;
				end
			end else if (op.valid && op_ready) begin
				ph_q <= ph_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= stream_byte;
			eos_s1  <= end_of_stream;
		end
	end

endmodule

[src/annexb_nal.sv]
// ----------------------------------------------------------------------------
// annexb_nal
// nal state: escape removal, header decode, error and length tracking
// ----------------------------------------------------------------------------
module annexb_nal
	import annexb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  op_t   op,
	input  logic  space,
	output logic  push,
	output item_t item
);

	logic                    open_q, err_q, ae_q, long_q;
	logic [1:0]              zr_q, hs_q;
	logic [15:0]             hdr_q;
	logic [LENGTH_WIDTH-1:0] cnt_q;

	logic                    open_n, err_n, ae_n, long_n;
	logic [1:0]              zr_n, hs_n;
	logic [15:0]             hdr_n;
	logic [LENGTH_WIDTH-1:0] cnt_n;

	logic        accept;
	logic        emit;
	logic        kind;
	logic        go;
	logic        hv;
	logic [15:0] hdr_sel;
	logic [7:0]  x;

	always_comb begin
		accept = op.valid && space;
		open_n = open_q;
		err_n  = err_q;
		ae_n   = ae_q;
		long_n = long_q;
		zr_n   = zr_q;
		hs_n   = hs_q;
		hdr_n  = hdr_q;
		cnt_n  = cnt_q;
		emit   = 1'b0;
		kind   = 1'b0;
		go     = 1'b0;
		x      = (op.code == OP_ZERO) ? BYTE_ZERO : op.data;
		unique case (op.code)
			OP_START: begin
				// a new start code closes the open nal first
				if (open_q) begin
					emit = 1'b1;
					kind = 1'b1;
				end
				open_n = 1'b1;
				long_n = op.long_sc;
				err_n  = 1'b0;
				ae_n   = 1'b0;
				zr_n   = 2'd0;
				hs_n   = 2'd0;
				hdr_n  = 16'h0000;
				cnt_n  = '0;
			end
			OP_CLOSE: begin
				if (open_q) begin
					emit   = 1'b1;
					kind   = 1'b1;
					open_n = 1'b0;
				end
			end
			OP_ZERO, OP_DATA: begin
				if (open_q && !err_q) begin
					go = 1'b1;
					if (ae_q) begin
						ae_n = 1'b0;
						if (x > BYTE_ESC) begin
							err_n = 1'b1;
							go    = 1'b0;
						end
					end
					if (go && zr_q >= RUN_MAX) begin
						if (x < BYTE_ESC) begin
							err_n = 1'b1;
							go    = 1'b0;
						end else if (x == BYTE_ESC) begin
							zr_n = 2'd0;
							ae_n = 1'b1;
							go   = 1'b0;
						end
					end
					if (go) begin
						if (hs_q == 2'd0) begin
							hdr_n = {x, 8'h00};
							hs_n  = 2'd1;
						end else if (hs_q == 2'd1) begin
							hdr_n = {hdr_q[15:8], x};
							hs_n  = HDR_DONE;
						end
						if (cnt_q != '1) begin
							cnt_n = cnt_q + LENGTH_WIDTH'(1);
						end
						if (x == BYTE_ZERO) begin
							if (zr_q < RUN_MAX) begin
								zr_n = zr_q + 2'd1;
							end
						end else begin
							zr_n = 2'd0;
						end
						emit = 1'b1;
					end
				end
			end
		endcase
		push = accept && emit;

		// markers report the nal being closed, payload items the updated state
		hv               = kind ? (hs_q == HDR_DONE) : (hs_n == HDR_DONE);
		hdr_sel          = kind ? hdr_q : hdr_n;
		item.kind        = kind;
		item.byte_val    = kind ? BYTE_ZERO : x;
		item.hdr_valid   = hv;
		item.forbidden   = hv ? hdr_sel[15] : 1'b0;
		item.unit_type   = hv ? hdr_sel[14:9] : 6'd0;
		item.layer_id    = hv ? {hdr_sel[8], hdr_sel[7:3]} : 6'd0;
		item.tid_plus1   = hv ? hdr_sel[2:0] : 3'd0;
		item.long_prefix = kind ? long_q : long_n;
		item.err         = kind ? err_q : 1'b0;
		item.length      = kind ? cnt_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			err_q  <= 1'b0;
			ae_q   <= 1'b0;
			long_q <= 1'b0;
			zr_q   <= 2'd0;
			hs_q   <= 2'd0;
			hdr_q  <= 16'h0000;
			cnt_q  <= '0;
		end else if (accept) begin
			open_q <= open_n;
			err_q  <= err_n;
			ae_q   <= ae_n;
			long_q <= long_n;
			zr_q   <= zr_n;
			hs_q   <= hs_n;
			hdr_q  <= hdr_n;
			cnt_q  <= cnt_n;
		end
	end

endmodule

[src/annexb_obuf.sv]
// ----------------------------------------------------------------------------
// annexb_obuf
// two-entry result buffer between the nal stage and the output channel
// ----------------------------------------------------------------------------
module annexb_obuf
	import annexb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t item_in,
	output logic  space,
	output logic  item_valid,
	input  logic  item_stall,
	output item_t item_out
);

	item_t      mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign space      = !cnt_q[1];
	assign item_valid = (cnt_q != 2'd0);
	assign pop        = item_valid && !item_stall;
	assign item_out   = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= item_in;
		end
	end

endmodule

[src/annexb_nal_deframer_core.sv]
// ----------------------------------------------------------------------------
// annexb_nal_deframer_core
// h.265 annex b start code finder and emulation prevention remover
// ----------------------------------------------------------------------------
// usage:
//   byte channel (byte_valid/byte_stall) takes one stream byte per transaction,
//   end_of_stream marks the last byte and closes the open nal.
//   item channel (item_valid/item_stall) returns payload bytes and one
//   end-of-nal marker per nal with its length and error flag.
//   a byte is registered in the input register and its items in the result
//   buffer. throughput: one byte per cycle while the buffer has space and
//   each byte needs at most one operation; a byte that releases n held zeros
//   becomes n zero operations and its own, and end of stream adds a close
//   operation for the marker. the rate is set by the sequencer, which hands
//   one operation per cycle to the nal state stage while the buffer has space.
//   a two-entry result buffer lets the next operation proceed while one
//   result waits; when the receiver stalls, the buffer fills, the sequencer
//   holds and byte_stall is high in every cycle the buffer is full while a
//   byte that needs an operation waits in the input register.
//   reset clears all control state; no items are offered until the first
//   start code.
// ----------------------------------------------------------------------------
module annexb_nal_deframer_core
	import annexb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  logic [7:0]              stream_byte,
	input  logic                    end_of_stream,
	output logic                    item_valid,
	input  logic                    item_stall,
	output logic                    item_kind,
	output logic [7:0]              payload_byte,
	output logic                    header_valid,
	output logic                    forbidden_bit,
	output logic [5:0]              unit_type,
	output logic [5:0]              layer_id,
	output logic [2:0]              temporal_id_plus1,
	output logic                    long_prefix,
	output logic                    syntax_error,
	output logic [LENGTH_WIDTH-1:0] rbsp_length
);

	op_t   op;
	logic  space;
	logic  push;
	item_t nal_item;
	item_t out_item;

	annexb_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.stream_byte   (stream_byte),
		.end_of_stream (end_of_stream),
		.op_ready      (space),
		.op            (op)
	);

	annexb_nal u_nal (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.space  (space),
		.push   (push),
		.item   (nal_item)
	);

	annexb_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item_in    (nal_item),
		.space      (space),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_out   (out_item)
	);

	assign item_kind         = out_item.kind;
	assign payload_byte      = out_item.byte_val;
	assign header_valid      = out_item.hdr_valid;
	assign forbidden_bit     = out_item.forbidden;
	assign unit_type         = out_item.unit_type;
	assign layer_id          = out_item.layer_id;
	assign temporal_id_plus1 = out_item.tid_plus1;
	assign long_prefix       = out_item.long_prefix;
	assign syntax_error      = out_item.err;
	assign rbsp_length       = out_item.length;

endmodule

[src/annexb_chk.sv]
// ----------------------------------------------------------------------------
// annexb_chk
// port-level checks of the deframer output, bound to the top level
// ----------------------------------------------------------------------------
`include "annexb_nal_deframer_core_macros.svh"

module annexb_chk
	import annexb_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_stall,
	input logic                    item_kind,
	input logic [7:0]              payload_byte,
	input logic                    header_valid,
	input logic                    forbidden_bit,
	input logic [5:0]              unit_type,
	input logic [5:0]              layer_id,
	input logic [2:0]              temporal_id_plus1,
	input logic                    syntax_error,
	input logic [LENGTH_WIDTH-1:0] rbsp_length
);

	`ANNEXB_ASSERT_NEXT(a_item_hold, clk, arst_n, item_valid && item_stall, item_valid && $stable(payload_byte) && $stable(item_kind), "stalled item changed")
	`ANNEXB_ASSERT_IMPL(a_payload_clean, clk, arst_n, item_valid && !item_kind, !syntax_error && (rbsp_length == '0), "payload item carries marker fields")
	`ANNEXB_ASSERT_IMPL(a_marker_clean, clk, arst_n, item_valid && item_kind, payload_byte == 8'h00, "marker carries a payload byte")
	`ANNEXB_ASSERT_IMPL(a_header_zero, clk, arst_n, item_valid && !header_valid, !forbidden_bit && (unit_type == 6'd0) && (layer_id == 6'd0) && (temporal_id_plus1 == 3'd0), "header fields set before header complete")

endmodule

bind annexb_nal_deframer_core annexb_chk u_chk (.*);

[test/annexb_nal_deframer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annexb_nal_deframer_core_tb
// self-checking bench for the annex b nal deframer: a byte driver and an item
// monitor with random idle bursts on both channels; every accepted byte is run
// through a local deframer model and each returned item is checked in order
// ----------------------------------------------------------------------------
module annexb_nal_deframer_core_tb;
	import annexb_pkg::*;

	localparam logic       KIND_PAYLOAD = 1'b0;
	localparam logic       KIND_MARKER  = 1'b1;
	localparam logic [1:0] SHORT_ZEROS  = 2'd2;
	localparam int         RANDOM_BYTES = 340;
	localparam int         TAIL_BYTES   = 40;
	localparam int         MAX_REPORTS  = 10;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_entry_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    byte_valid = 1'b0;
	logic                    byte_stall;
	logic [7:0]              stream_byte = 8'h00;
	logic                    end_of_stream = 1'b0;
	logic                    item_valid;
	logic                    item_stall = 1'b0;
	logic                    item_kind;
	logic [7:0]              payload_byte;
	logic                    header_valid;
	logic                    forbidden_bit;
	logic [5:0]              unit_type;
	logic [5:0]              layer_id;
	logic [2:0]              temporal_id_plus1;
	logic                    long_prefix;
	logic                    syntax_error;
	logic [LENGTH_WIDTH-1:0] rbsp_length;

	annexb_nal_deframer_core DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.byte_stall        (byte_stall),
		.stream_byte       (stream_byte),
		.end_of_stream     (end_of_stream),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.item_kind         (item_kind),
		.payload_byte      (payload_byte),
		.header_valid      (header_valid),
		.forbidden_bit     (forbidden_bit),
		.unit_type         (unit_type),
		.layer_id          (layer_id),
		.temporal_id_plus1 (temporal_id_plus1),
		.long_prefix       (long_prefix),
		.syntax_error      (syntax_error),
		.rbsp_length       (rbsp_length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// deframer model state
	logic [1:0]              zeros_held;
	logic [1:0]              zero_run;
	logic                    escape_pending;
	logic                    in_nal;
	logic                    nal_error;
	logic [1:0]              hdr_count;
	logic [15:0]             hdr_word;
	logic                    nal_long;
	logic [LENGTH_WIDTH-1:0] rbsp_count;

	stream_entry_t stream_pending[$];
	item_t         rbsp_expected[$];

	stream_entry_t next_entry;
	item_t         got_item;
	item_t         want_item;
	int            send_gap;
	int            recv_gap;
	int            idle_odds;
	int            cycle_count;
	int            bytes_total;
	int            bytes_accepted;
	int            items_checked;
	int            markers_checked;
	int            error_markers;
	int            fail_count;

	function automatic void clear_deframer();
		zeros_held     = '0;
		zero_run       = '0;
		escape_pending = 1'b0;
		in_nal         = 1'b0;
		nal_error      = 1'b0;
		hdr_count      = '0;
		hdr_word       = '0;
		nal_long       = 1'b0;
		rbsp_count     = '0;
	endfunction

	function automatic void emit_item(input logic marker, input logic [7:0] data);
		item_t it;
		logic  hv;
		hv             = (hdr_count >= HDR_DONE);
		it.kind        = marker;
		it.byte_val    = marker ? BYTE_ZERO : data;
		it.hdr_valid   = hv;
		it.forbidden   = hv ? hdr_word[15] : 1'b0;
		it.unit_type   = hv ? hdr_word[14:9] : 6'd0;
		it.layer_id    = hv ? {hdr_word[8], hdr_word[7:3]} : 6'd0;
		it.tid_plus1   = hv ? hdr_word[2:0] : 3'd0;
		it.long_prefix = nal_long;
		it.err         = marker ? nal_error : 1'b0;
		it.length      = marker ? rbsp_count : '0;
		rbsp_expected  = {rbsp_expected, it};
	endfunction

	function automatic void feed_payload(input logic [7:0] x);
		if (!in_nal || nal_error)
			return;
		if (escape_pending) begin
			escape_pending = 1'b0;
			if (x > BYTE_ESC) begin
				nal_error = 1'b1;
				return;
			end
		end
		if (zero_run >= RUN_MAX) begin
			if (x < BYTE_ESC) begin
				nal_error = 1'b1;
				return;
			end
			if (x == BYTE_ESC) begin
				zero_run       = '0;
				escape_pending = 1'b1;
				return;
			end
		end
		if (hdr_count == 2'd0) begin
			hdr_word  = {x, 8'h00};
			hdr_count = 2'd1;
		end else if (hdr_count == 2'd1) begin
			hdr_word[7:0] = x;
			hdr_count     = HDR_DONE;
		end
		if (rbsp_count != {LENGTH_WIDTH{1'b1}})
			rbsp_count = rbsp_count + LENGTH_WIDTH'(1);
		if (x == BYTE_ZERO) begin
			if (zero_run < RUN_MAX)
				zero_run = zero_run + 2'd1;
		end else begin
			zero_run = '0;
		end
		emit_item(KIND_PAYLOAD, x);
	endfunction

	function automatic void close_nal();
		if (in_nal) begin
			emit_item(KIND_MARKER, BYTE_ZERO);
			in_nal = 1'b0;
		end
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input logic eos);
		int   k;
		logic four_byte;
		if (b == BYTE_ZERO) begin
			if (zeros_held < HELD_MAX)
				zeros_held = zeros_held + 2'd1;
		end else if (b == BYTE_ONE && zeros_held >= SHORT_ZEROS) begin
			four_byte  = (zeros_held >= HELD_MAX);
			zeros_held = '0;
			close_nal();
			in_nal         = 1'b1;
			nal_long       = four_byte;
			nal_error      = 1'b0;
			escape_pending = 1'b0;
			zero_run       = '0;
			hdr_count      = '0;
			hdr_word       = '0;
			rbsp_count     = '0;
		end else begin
			for (k = 0; k < zeros_held; k++)
				feed_payload(BYTE_ZERO);
			zeros_held = '0;
			feed_payload(b);
		end
		if (eos) begin
			zeros_held = '0;
			close_nal();
			clear_deframer();
		end
	endfunction

	function automatic string describe_item(input item_t it);
		return $sformatf({"kind=%0d byte=%02h hv=%0d f=%0d type=%0d layer=%0d",
			" tid=%0d long=%0d err=%0d len=%0d"},
			it.kind, it.byte_val, it.hdr_valid, it.forbidden, it.unit_type, it.layer_id,
			it.tid_plus1, it.long_prefix, it.err, it.length);
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic eos);
		stream_entry_t e;
		e.data         = b;
		e.last         = eos;
		stream_pending = {stream_pending, e};
	endtask

	task automatic queue_seq(input logic [7:0] seq[$]);
		foreach (seq[i])
			queue_byte(seq[i], 1'b0);
	endtask

	task automatic mark_last();
		stream_pending[stream_pending.size() - 1].last = 1'b1;
	endtask

	task automatic build_random_stream();
		int target;
		int len;
		int r;
		target = stream_pending.size() + RANDOM_BYTES;
		while (stream_pending.size() < target) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3))
					queue_byte(8'($urandom_range(0, 255)), 1'b0);
			end
			r = $urandom_range(0, 5);
			if (r == 0)
				queue_seq('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
			else if (r < 3)
				queue_seq('{8'h00, 8'h00, 8'h00, 8'h01});
			else
				queue_seq('{8'h00, 8'h00, 8'h01});
			queue_byte(8'($urandom_range(0, 255)), 1'b0);
			queue_byte(8'($urandom_range(0, 255)), 1'b0);
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 10);
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					queue_byte(8'($urandom_range(1, 255)), 1'b0);
				else if (r < 75)
					queue_byte(BYTE_ZERO, 1'b0);
				else if (r < 87)
					queue_seq('{8'h00, 8'h00, 8'h03, 8'($urandom_range(0, 3))});
				else if (r < 93)
					queue_seq('{8'h00, 8'h00, 8'h03, 8'($urandom_range(4, 255))});
				else
					queue_seq('{8'h00, 8'h00, 8'($urandom_range(0, 2))});
			end
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(0, 3))
					queue_byte(BYTE_ZERO, 1'b0);
				mark_last();
			end
		end
		queue_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid    <= 1'b0;
			stream_byte   <= 8'h00;
			end_of_stream <= 1'b0;
			send_gap      <= 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				deframe_byte(stream_byte, end_of_stream);
				bytes_accepted++;
			end
			if (!byte_valid || !byte_stall) begin
				if (send_gap > 0) begin
					send_gap   <= send_gap - 1;
					byte_valid <= 1'b0;
				end else if (stream_pending.size() > TAIL_BYTES &&
						$urandom_range(0, 15) < idle_odds * 3) begin
					send_gap   <= $urandom_range(0, 18);
					byte_valid <= 1'b0;
				end else if (stream_pending.size() > 0) begin
					next_entry     = stream_pending.pop_front();
					byte_valid    <= 1'b1;
					stream_byte   <= next_entry.data;
					end_of_stream <= next_entry.last;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// item monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_stall  <= 1'b0;
			recv_gap    <= 0;
			idle_odds   <= 0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count % 128 == 0)
				idle_odds <= $urandom_range(0, 2);
			if (item_valid && !item_stall) begin
				got_item.kind        = item_kind;
				got_item.byte_val    = payload_byte;
				got_item.hdr_valid   = header_valid;
				got_item.forbidden   = forbidden_bit;
				got_item.unit_type   = unit_type;
				got_item.layer_id    = layer_id;
				got_item.tid_plus1   = temporal_id_plus1;
				got_item.long_prefix = long_prefix;
				got_item.err         = syntax_error;
				got_item.length      = rbsp_length;
				if (rbsp_expected.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t unexpected item: %s", $realtime, describe_item(got_item));
					fail_count++;
				end else begin
					want_item = rbsp_expected.pop_front();
					if (got_item !== want_item) begin
						if (fail_count < MAX_REPORTS) begin
							$display("%0t item mismatch", $realtime);
							$display("  expected %s", describe_item(want_item));
							$display("  actual   %s", describe_item(got_item));
						end
						fail_count++;
					end
					items_checked++;
					if (want_item.kind == KIND_MARKER) begin
						markers_checked++;
						if (want_item.err)
							error_markers++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap   <= recv_gap - 1;
				item_stall <= 1'b1;
			end else if (stream_pending.size() > TAIL_BYTES &&
					$urandom_range(0, 15) < idle_odds * 3) begin
				recv_gap   <= $urandom_range(0, 18);
				item_stall <= 1'b1;
			end else begin
				item_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("Verification failed");
		$finish;
	end

	initial begin
		clear_deframer();
		bytes_accepted  = 0;
		items_checked   = 0;
		markers_checked = 0;
		error_markers   = 0;
		fail_count      = 0;

		// junk before the first start code
		queue_byte(8'h55, 1'b0);
		// short start, header, escape inside and escape at the end
		queue_seq('{8'h00, 8'h00, 8'h01, 8'h40, 8'h01, 8'h00, 8'h00, 8'h03,
			8'h01, 8'h00, 8'h00, 8'h03});
		// surplus zeros into a long start, all-ones header, released zeros flagged
		queue_seq('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00,
			8'h00, 8'h00, 8'h2A});
		// bad byte after escape, stream ends on held zeros
		queue_seq('{8'h00, 8'h00, 8'h01, 8'h7E, 8'h00, 8'h00, 8'h03, 8'h05,
			8'h00});
		queue_byte(8'h00, 1'b1);
		// start code on the last byte
		queue_seq('{8'h00, 8'h00});
		queue_byte(8'h01, 1'b1);

		build_random_stream();
		bytes_total = stream_pending.size();

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bytes_accepted < bytes_total)
			@(posedge clk);
		while (rbsp_expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (rbsp_expected.size() > 0) begin
			$display("%0d expected items never arrived", rbsp_expected.size());
			fail_count += rbsp_expected.size();
		end
		$display("sent %0d stream bytes, checked %0d items including %0d nal markers",
			bytes_accepted, items_checked, markers_checked);
		$display("%0d nals closed with syntax error, %0d failures", error_markers, fail_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
